### rtl/core/usdst_pkg.sv
`default_nettype none

package usdst_pkg;

    localparam int unsigned SEC_W   = 32;
    localparam int unsigned ZONE_W  = 17;
    localparam int unsigned DAY_W   = 16;
    localparam int unsigned DOE_W   = 18;
    localparam int unsigned YOE_W   = 9;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned MP_W    = 4;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned WDAY_W  = 3;

    localparam logic signed [ZONE_W-1:0] ZONE_RESET = -17'sd18000;

    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [16:0] SWITCH_SECS  = 17'd7200;
    localparam logic [SEC_W:0] DST_SHIFT = 33'd3600;
    localparam logic [SEC_W-1:0] SEC_MAX = '1;

    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

    localparam logic [19:0] EPOCH_SHIFT = 20'd719468;
    localparam logic [19:0] ERA4_BASE   = 20'd584388;
    localparam logic [19:0] ERA5_BASE   = 20'd730485;
    localparam logic [DOE_W-1:0] ERA_LAST_DAY = 18'd146096;

    // ceiling reciprocals, exact over the input range of each divide
    localparam logic [25:0] RECIP_675   = 26'(((64'd1 << 35) + 64'd674) / 64'd675);
    localparam logic [18:0] RECIP_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] RECIP_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [18:0] RECIP_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  RECIP_100   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] RECIP_153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

    // seconds / 86400 as (seconds >> 7) / 675
    function automatic logic [DAY_W-1:0] day_of(input logic [SEC_W-1:0] secs);
        logic [50:0] prod;
        begin
            prod = 51'(secs[31:7]) * 51'(RECIP_675);
            return prod[50:35];
        end
    endfunction

    function automatic logic [6:0] div_1460(input logic [DOE_W-1:0] x);
        logic [36:0] prod;
        begin
            prod = 37'(x) * 37'(RECIP_1460);
            return prod[35:29];
        end
    endfunction

    function automatic logic [2:0] div_36524(input logic [DOE_W-1:0] x);
        logic [36:0] prod;
        begin
            prod = 37'(x) * 37'(RECIP_36524);
            return prod[36:34];
        end
    endfunction

    function automatic logic [YOE_W-1:0] div_365(input logic [DOE_W-1:0] x);
        logic [36:0] prod;
        begin
            prod = 37'(x) * 37'(RECIP_365);
            return prod[35:27];
        end
    endfunction

    function automatic logic [2:0] div_100(input logic [YOE_W-1:0] x);
        logic [18:0] prod;
        begin
            prod = 19'(x) * 19'(RECIP_100);
            return prod[18:16];
        end
    endfunction

    function automatic logic [MP_W-1:0] div_153(input logic [10:0] x);
        logic [22:0] prod;
        begin
            prod = 23'(x) * 23'(RECIP_153);
            return prod[22:19];
        end
    endfunction

    // day of year (from march 1) at which each shifted month starts
    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] r;
        begin
            case (mp)
                4'd0:    r = 9'd0;
                4'd1:    r = 9'd31;
                4'd2:    r = 9'd61;
                4'd3:    r = 9'd92;
                4'd4:    r = 9'd122;
                4'd5:    r = 9'd153;
                4'd6:    r = 9'd184;
                4'd7:    r = 9'd214;
                4'd8:    r = 9'd245;
                4'd9:    r = 9'd275;
                4'd10:   r = 9'd306;
                4'd11:   r = 9'd337;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // x mod 7 by folding octal digits, since 8 is 1 mod 7
    function automatic logic [WDAY_W-1:0] mod_7(input logic [DAY_W:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        begin
            s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
               + 6'(x[14:12]) + 6'(x[16:15]);
            s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
            return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/usdst_civil.sv
`default_nettype none

module usdst_civil
    import usdst_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [DAY_W-1:0]   days_in,
    output logic      [DAY_W-1:0]   days,
    output logic      [MONTH_W-1:0] month,
    output logic      [DAY_W-1:0]   first_day,
    output logic      [WDAY_W-1:0]  first_wday
);

    logic [19:0]        z;
    logic [DOE_W-1:0]   doe_next;
    logic [DOE_W-1:0]   t_next;
    logic [YOE_W-1:0]   yoe_next;
    logic [DOE_W-1:0]   yr_days;
    logic [DOY_W-1:0]   doy_next;
    logic [10:0]        mp_num;
    logic [MP_W-1:0]    mp_next;
    logic [MONTH_W-1:0] month_next;
    logic [DAY_W-1:0]   first_next;
    logic [WDAY_W-1:0]  wday_next;

    logic [DAY_W-1:0]   days_reg [1:7];
    logic [DOE_W-1:0]   doe1_reg;
    logic [DOE_W-1:0]   doe2_reg;
    logic [DOE_W-1:0]   doe3_reg;
    logic [DOE_W-1:0]   t2_reg;
    logic [YOE_W-1:0]   yoe3_reg;
    logic [DOY_W-1:0]   doy4_reg;
    logic [DOY_W-1:0]   doy5_reg;
    logic [MP_W-1:0]    mp5_reg;
    logic [MONTH_W-1:0] month6_reg;
    logic [MONTH_W-1:0] month7_reg;
    logic [DAY_W-1:0]   first6_reg;
    logic [DAY_W-1:0]   first7_reg;
    logic [WDAY_W-1:0]  wday7_reg;

    // day of era, era 4 or era 5 for every 32-bit time
    always_comb
    begin
        z = 20'(days_in) + EPOCH_SHIFT;
        if (z >= ERA5_BASE)
        begin
            doe_next = DOE_W'(z - ERA5_BASE);
        end
        else
        begin
            doe_next = DOE_W'(z - ERA4_BASE);
        end
    end

    assign t_next = doe1_reg - DOE_W'(div_1460(doe1_reg)) + DOE_W'(div_36524(doe1_reg))
                  - DOE_W'(doe1_reg == ERA_LAST_DAY);

    assign yoe_next = div_365(t2_reg);

    assign yr_days  = DOE_W'(yoe3_reg) * 18'd365 + DOE_W'(yoe3_reg >> 2)
                    - DOE_W'(div_100(yoe3_reg));
    assign doy_next = DOY_W'(doe3_reg - yr_days);

    assign mp_num  = 11'(doy4_reg) * 11'd5 + 11'd2;
    assign mp_next = div_153(mp_num);

    assign month_next = (mp5_reg < 4'd10) ? (mp5_reg + 4'd3) : (mp5_reg - 4'd9);
    assign first_next = days_reg[5] - DAY_W'(doy5_reg - month_start(mp5_reg));

    // 1970-01-01 was a thursday
    assign wday_next = mod_7(17'(first6_reg) + 17'd4);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            days_reg[1] <= days_in;
            for (int i = 2; i <= 7; i++)
            begin
                days_reg[i] <= days_reg[i-1];
            end
            doe1_reg   <= doe_next;
            doe2_reg   <= doe1_reg;
            t2_reg     <= t_next;
            doe3_reg   <= doe2_reg;
            yoe3_reg   <= yoe_next;
            doy4_reg   <= doy_next;
            doy5_reg   <= doy4_reg;
            mp5_reg    <= mp_next;
            month6_reg <= month_next;
            first6_reg <= first_next;
            month7_reg <= month6_reg;
            first7_reg <= first6_reg;
            wday7_reg  <= wday_next;
        end
    end

    assign days       = days_reg[7];
    assign month      = month7_reg;
    assign first_day  = first7_reg;
    assign first_wday = wday7_reg;

endmodule

`default_nettype wire

### rtl/core/us_dst_offset_from_epoch_top.sv
// one result per input
// throughput: one transfer per cycle; the eleven-stage pipeline holds as a whole
//   while a finished result is stalled at the output
// reset: rst_n clears all stage valid bits and loads the zone offset with -18000
`default_nettype none

module us_dst_offset_from_epoch_top
    import usdst_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic signed [ZONE_W-1:0] zone_offset_seconds,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic        [SEC_W-1:0]  utc_seconds,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic             [SEC_W-1:0]  local_seconds,
    output logic                          dst_active
);

    localparam int unsigned NSTAGE = 11;

    logic                     advance;
    logic signed [ZONE_W-1:0] zone_reg;
    logic [NSTAGE:1]          vld_reg;

    logic signed [SEC_W+1:0]  sum;
    logic [SEC_W-1:0]         lst_next;
    logic [SEC_W-1:0]         lst1_reg;
    logic [SEC_W-1:0]         lst2_reg;
    logic [DAY_W-1:0]         days2_reg;
    logic [16:0]              sod;
    logic                     sod_ge_next;
    logic [SEC_W-1:0]         lst_pipe_reg [3:9];
    logic                     sod_ge_pipe_reg [3:9];

    logic [DAY_W-1:0]         c_days;
    logic [MONTH_W-1:0]       c_month;
    logic [DAY_W-1:0]         c_first;
    logic [WDAY_W-1:0]        c_wday;

    logic [WDAY_W-1:0]        first_sun;
    logic [DAY_W-1:0]         sun_next;
    logic [SEC_W-1:0]         lst10_reg;
    logic                     sod_ge10_reg;
    logic [DAY_W-1:0]         days10_reg;
    logic [DAY_W-1:0]         sun10_reg;
    logic [MONTH_W-1:0]       month10_reg;

    logic                     dst_next;
    logic [SEC_W:0]           local_sum;
    logic [SEC_W-1:0]         local_next;
    logic [SEC_W-1:0]         local_reg;
    logic                     dst_reg;

    assign advance  = !(vld_reg[NSTAGE] && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= ZONE_RESET;
        end
        else if (cfg_write)
        begin
            zone_reg <= zone_offset_seconds;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NSTAGE-1:1], in_valid};
        end
    end

    // local standard time, saturated
    always_comb
    begin
        sum = $signed({2'b00, utc_seconds}) + (SEC_W+2)'(zone_reg);
        if (sum[SEC_W+1])
        begin
            lst_next = '0;
        end
        else if (sum[SEC_W])
        begin
            lst_next = SEC_MAX;
        end
        else
        begin
            lst_next = sum[SEC_W-1:0];
        end
    end

    assign sod         = 17'(lst2_reg - SEC_W'(days2_reg) * SEC_W'(SECS_PER_DAY));
    assign sod_ge_next = (sod >= SWITCH_SECS);

    usdst_civil u_civil (
        .clk        (clk),
        .en         (advance),
        .days_in    (days2_reg),
        .days       (c_days),
        .month      (c_month),
        .first_day  (c_first),
        .first_wday (c_wday)
    );

    // switch day: second sunday in march, first sunday in november
    assign first_sun = (c_wday == '0) ? '0 : 3'(3'd7 - c_wday);
    assign sun_next  = c_first + DAY_W'(first_sun)
                     + ((c_month == MONTH_MAR) ? DAY_W'(7) : DAY_W'(0));

    always_comb
    begin
        if (month10_reg > MONTH_MAR && month10_reg < MONTH_NOV)
        begin
            dst_next = 1'b1;
        end
        else if (month10_reg == MONTH_MAR)
        begin
            dst_next = (days10_reg > sun10_reg)
                    || (days10_reg == sun10_reg && sod_ge10_reg);
        end
        else if (month10_reg == MONTH_NOV)
        begin
            dst_next = (days10_reg < sun10_reg)
                    || (days10_reg == sun10_reg && !sod_ge10_reg);
        end
        else
        begin
            dst_next = 1'b0;
        end
    end

    assign local_sum  = {1'b0, lst10_reg} + (dst_next ? DST_SHIFT : '0);
    assign local_next = local_sum[SEC_W] ? SEC_MAX : local_sum[SEC_W-1:0];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lst1_reg  <= lst_next;
            lst2_reg  <= lst1_reg;
            days2_reg <= day_of(lst1_reg);
            lst_pipe_reg[3]    <= lst2_reg;
            sod_ge_pipe_reg[3] <= sod_ge_next;
            for (int i = 4; i <= 9; i++)
            begin
                lst_pipe_reg[i]    <= lst_pipe_reg[i-1];
                sod_ge_pipe_reg[i] <= sod_ge_pipe_reg[i-1];
            end
            lst10_reg    <= lst_pipe_reg[9];
            sod_ge10_reg <= sod_ge_pipe_reg[9];
            days10_reg   <= c_days;
            sun10_reg    <= sun_next;
            month10_reg  <= c_month;
            local_reg    <= local_next;
            dst_reg      <= dst_next;
        end
    end

    assign out_valid     = vld_reg[NSTAGE];
    assign local_seconds = local_reg;
    assign dst_active    = dst_reg;

    // input is held only by a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output stall");

    // daylight time only from march through november
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTAGE-1] && (month10_reg < MONTH_MAR || month10_reg > MONTH_NOV)
        |-> !dst_next)
        else $error("daylight flag outside march to november");

    // daylight hour is never lost by saturation at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dst_active |-> local_seconds >= 32'd3600)
        else $error("daylight result below one hour");

endmodule

`default_nettype wire

### tb/tb_us_dst_offset_from_epoch_top.sv
`default_nettype none

module tb_us_dst_offset_from_epoch_top;
    import usdst_pkg::*;

    localparam int     LATENCY   = 11;
    localparam int     LIMIT     = 500000;
    localparam int     HOLD_LEN  = 80;
    localparam longint SEC_TOP   = 64'h0000_0000_FFFF_FFFF;
    localparam longint DAY_SECS  = 86400;

    typedef struct {
        logic [SEC_W-1:0] secs;
        logic             dst;
    } local_time_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic signed [ZONE_W-1:0] zone_offset_seconds = ZONE_RESET;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic        [SEC_W-1:0]  utc_seconds = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic        [SEC_W-1:0]  local_seconds;
    logic                     dst_active;

    logic signed [ZONE_W-1:0] zone_cfg = ZONE_RESET;
    local_time_t              local_due[$];
    int                       in_flight = 0;
    int                       fail_count = 0;
    int                       stamps_sent = 0;
    int                       results_seen = 0;
    int                       dst_seen = 0;
    int                       zone_writes = 0;
    int                       input_stalls = 0;
    int                       cycle_count = 0;
    int                       burst_left = 0;
    bit                       gaps_on = 1'b0;
    bit                       hold_request = 1'b0;

    us_dst_offset_from_epoch_top u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write           (cfg_write),
        .zone_offset_seconds (zone_offset_seconds),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .utc_seconds         (utc_seconds),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .local_seconds       (local_seconds),
        .dst_active          (dst_active)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, in_flight);
            $display("tb_us_dst_offset_from_epoch_top failed");
            $finish;
        end
    end

    // day count since 1970-01-01 for a civil date
    function automatic longint day_number(input int y, input int m, input int d);
        longint yy, era, yoe, doy, doe;
        begin
            yy  = (m <= 2) ? y - 1 : y;
            era = yy / 400;
            yoe = yy - era * 400;
            doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return era * 146097 + doe - 719468;
        end
    endfunction

    // local standard time of the spring or fall switch in a given year
    function automatic longint switch_time(input int y, input int m);
        longint first, sun1;
        begin
            first = day_number(y, m, 1);
            sun1  = first + (7 - (first + 4) % 7) % 7;
            if (m == int'(MONTH_MAR))
                sun1 = sun1 + 7;
            return sun1 * DAY_SECS + 7200;
        end
    endfunction

    function automatic local_time_t to_local_time(input logic [SEC_W-1:0] utc,
                                                  input logic signed [ZONE_W-1:0] zone);
        local_time_t r;
        longint sum, lst, days, z, era, doe, yoe, doy, mp, mday, month, first, sun1, secs;
        begin
            sum = longint'({32'd0, utc}) + longint'(zone);
            if (sum < 0)
                lst = 0;
            else if (sum > SEC_TOP)
                lst = SEC_TOP;
            else
                lst = sum;
            days  = lst / DAY_SECS;
            z     = days + 719468;
            era   = z / 146097;
            doe   = z - era * 146097;
            yoe   = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy   = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp    = (5 * doy + 2) / 153;
            mday  = doy - (153 * mp + 2) / 5 + 1;
            month = (mp < 10) ? mp + 3 : mp - 9;
            first = days - (mday - 1);
            sun1  = first + (7 - (first + 4) % 7) % 7;
            if (month > longint'(MONTH_MAR) && month < longint'(MONTH_NOV))
                r.dst = 1'b1;
            else if (month == longint'(MONTH_MAR))
                r.dst = (lst >= (sun1 + 7) * DAY_SECS + 7200);
            else if (month == longint'(MONTH_NOV))
                r.dst = (lst < sun1 * DAY_SECS + 7200);
            else
                r.dst = 1'b0;
            secs = lst + (r.dst ? 3600 : 0);
            if (secs > SEC_TOP)
                secs = SEC_TOP;
            r.secs = secs[SEC_W-1:0];
            return r;
        end
    endfunction

    // utc time that lands on a given local standard time under the current zone
    function automatic logic [SEC_W-1:0] aim(input longint lst);
        longint u;
        begin
            u = lst - longint'(zone_cfg);
            if (u < 0)
                u = 0;
            else if (u > SEC_TOP)
                u = SEC_TOP;
            return u[SEC_W-1:0];
        end
    endfunction

    function automatic longint jitter();
        longint j;
        begin
            case ($urandom_range(0, 3))
                0:       j = longint'($urandom_range(0, 2)) - 1;
                1:       j = longint'($urandom_range(0, 7200)) - 3600;
                2:       j = longint'($urandom_range(0, 172800)) - 86400;
                default: j = longint'($urandom_range(0, 1209600)) - 604800;
            endcase
            return j;
        end
    endfunction

    function automatic logic [SEC_W-1:0] pick_stamp();
        int unsigned kind;
        int          y;
        begin
            kind = $urandom_range(0, 99);
            y    = $urandom_range(1970, 2105);
            if (kind < 40)
                return aim(switch_time(y, ($urandom_range(0, 1) != 0) ?
                                          int'(MONTH_MAR) : int'(MONTH_NOV)) + jitter());
            else if (kind < 55)
                return aim(day_number(y, $urandom_range(1, 12), 1) * DAY_SECS + jitter());
            else if (kind < 65)
                return ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 70000)) :
                                                     32'hFFFF_FFFF - $urandom_range(0, 70000);
            else
                return $urandom();
        end
    endfunction

    task automatic send_stamp(input logic [SEC_W-1:0] stamp);
        in_valid    <= 1'b1;
        utc_seconds <= stamp;
        do
        begin
            @(posedge clk);
            if (in_stall)
                input_stalls++;
        end
        while (in_stall);
        local_due.push_back(to_local_time(stamp, zone_cfg));
        in_flight++;
        stamps_sent++;
    endtask

    task automatic pace();
        int gap;
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if (gaps_on)
                begin
                    gap = $urandom_range(1, 12);
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            else
                burst_left--;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (in_flight == 0);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_zone(input logic signed [ZONE_W-1:0] zone);
        drain();
        cfg_write           <= 1'b1;
        zone_offset_seconds <= zone;
        @(posedge clk);
        cfg_write <= 1'b0;
        zone_cfg = zone;
        zone_writes++;
        @(posedge clk);
    endtask

    // receiver: long hold on request, otherwise stall pattern of its own
    initial
    begin : receiver
        int mode;
        int pattern_left;
        int hold_cycles;
        mode = 0;
        pattern_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                hold_cycles = 0;
                while (hold_cycles < HOLD_LEN)
                begin
                    @(posedge clk);
                    hold_cycles++;
                end
                out_stall <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    pattern_left = $urandom_range(10, 200);
                end
                else
                    pattern_left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        local_time_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (local_due.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected transfer: expected none, actual local %0d dst %0b",
                         $time, local_seconds, dst_active);
            end
            else
            begin
                want = local_due.pop_front();
                in_flight--;
                results_seen++;
                if (want.dst)
                    dst_seen++;
                if (local_seconds !== want.secs)
                begin
                    fail_count++;
                    $display("%0t: local_seconds mismatch: expected %0d actual %0d",
                             $time, want.secs, local_seconds);
                end
                if (dst_active !== want.dst)
                begin
                    fail_count++;
                    $display("%0t: dst_active mismatch: expected %0b actual %0b",
                             $time, want.dst, dst_active);
                end
            end
        end
    end

    task automatic test_reset_zone();
        longint spring, fall, apr1, nov1;
        begin
            spring = switch_time(2024, int'(MONTH_MAR));
            fall   = switch_time(2024, int'(MONTH_NOV));
            apr1   = day_number(2024, 4, 1) * DAY_SECS;
            nov1   = day_number(2024, 11, 1) * DAY_SECS;
            send_stamp(32'd0);
            send_stamp(aim(0));
            send_stamp(32'hFFFF_FFFF);
            send_stamp(aim(spring - 1));
            send_stamp(aim(spring));
            send_stamp(aim(fall - 1));
            send_stamp(aim(fall));
            send_stamp(aim(apr1 - 1));
            send_stamp(aim(apr1));
            send_stamp(aim(nov1 - 1));
            send_stamp(aim(day_number(2024, 12, 1) * DAY_SECS));
            send_stamp(aim(day_number(2024, 2, 29) * DAY_SECS + 43200));
        end
    endtask

    task automatic test_zone_extremes();
        write_zone(17'sd50400);
        send_stamp(32'hFFFF_FFFF);
        send_stamp(32'hFFFF_FFFF - 32'd50400);
        send_stamp(32'd0);
        write_zone(-17'sd50400);
        send_stamp(32'd0);
        send_stamp(32'd50399);
        send_stamp(32'd50400);
        write_zone(17'h10000);
        send_stamp(32'd65535);
        send_stamp(32'd65536);
        write_zone(17'h0FFFF);
        send_stamp(32'hFFFF_FFFF);
        send_stamp(32'd0);
        write_zone('0);
        send_stamp(aim(switch_time(1970, int'(MONTH_MAR))));
        send_stamp(aim(switch_time(2105, int'(MONTH_NOV)) - 1));
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        begin
            for (phase = 0; phase < 6; phase++)
            begin
                if (phase == 5)
                    write_zone(ZONE_W'($urandom()));
                else
                    write_zone(ZONE_W'(int'($urandom_range(0, 100800)) - 50400));
                gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
                burst_left = 0;
                for (n = 0; n < 190; n++)
                begin
                    send_stamp(pick_stamp());
                    pace();
                end
            end
        end
    endtask

    task automatic test_backpressure();
        int n;
        begin
            write_zone(ZONE_RESET);
            hold_request = 1'b1;
            for (n = 0; n < 60; n++)
                send_stamp(pick_stamp());
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_zone();
        test_zone_extremes();
        test_random_traffic();
        test_backpressure();
        drain();
        repeat (2 * LATENCY) @(posedge clk);
        $display("covered %0d timestamps under %0d zone writes; %0d results, %0d in daylight time",
                 stamps_sent, zone_writes, results_seen, dst_seen);
        $display("input held off for %0d cycles while offering a transfer", input_stalls);
        if (fail_count == 0)
            $display("tb_us_dst_offset_from_epoch_top passed");
        else
            $display("tb_us_dst_offset_from_epoch_top failed");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/core/usdst_pkg.sv
rtl/core/usdst_civil.sv
rtl/core/us_dst_offset_from_epoch_top.sv
tb/tb_us_dst_offset_from_epoch_top.sv
